// ----- rtl/core/bnid_pkg.sv -----
package bnid_pkg;

	localparam int COUNT_BITS = 16;
	localparam int NUM_DENOMS = 7;
	localparam int IDX_BITS   = $clog2(NUM_DENOMS);

	localparam int OP_BITS    = 2;
	localparam int VALUE_BITS = 8;
	localparam int QTY_BITS   = 16;
	localparam int REM_BITS   = 24;
	localparam int OUT_BITS   = 16;

	// Deposit sum keeps one carry bit above the wider of count and quantity.
	localparam int SUM_BITS   = ((COUNT_BITS > QTY_BITS) ? COUNT_BITS : QTY_BITS) + 1;
	localparam int WIDE_BITS  = (COUNT_BITS > REM_BITS) ? COUNT_BITS : REM_BITS;
	// The face values add up to 188, so eight bits above a count hold the full total.
	localparam int TOTAL_BITS = ((COUNT_BITS + 8) > (REM_BITS + 1)) ?
		(COUNT_BITS + 8) : (REM_BITS + 1);

	// Quotient by a face value is a multiply by a rounded-up reciprocal of 2^31.
	// The rounding error stays below 2^31 / face for any 24-bit remainder, so it is exact.
	localparam int RECIP_SHIFT = 31;
	localparam int MAGIC_BITS  = 32;
	localparam int PROD_BITS   = REM_BITS + MAGIC_BITS;
	localparam longint unsigned RECIP_BASE = 64'd1 << RECIP_SHIFT;

	localparam logic [VALUE_BITS-1:0] FACE [NUM_DENOMS] = '{
		8'd1, 8'd2, 8'd5, 8'd10, 8'd20, 8'd50, 8'd100
	};

	localparam logic [MAGIC_BITS-1:0] MAGIC [NUM_DENOMS] = '{
		MAGIC_BITS'((RECIP_BASE + 64'd0) / 64'd1),
		MAGIC_BITS'((RECIP_BASE + 64'd1) / 64'd2),
		MAGIC_BITS'((RECIP_BASE + 64'd4) / 64'd5),
		MAGIC_BITS'((RECIP_BASE + 64'd9) / 64'd10),
		MAGIC_BITS'((RECIP_BASE + 64'd19) / 64'd20),
		MAGIC_BITS'((RECIP_BASE + 64'd49) / 64'd50),
		MAGIC_BITS'((RECIP_BASE + 64'd99) / 64'd100)
	};

	typedef enum logic [OP_BITS-1:0] {
		OP_DEPOSIT  = 2'd0,
		OP_WITHDRAW = 2'd1,
		OP_QUERY    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_UNAVAIL  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic [OP_BITS-1:0]    op;
		logic [VALUE_BITS-1:0] note_value;
		logic [QTY_BITS-1:0]   note_quantity;
		logic [REM_BITS-1:0]   amount;
	} in_item_t;

	typedef struct packed {
		status_t               status;
		logic [REM_BITS-1:0]   total_value;
		logic [OUT_BITS-1:0]   count_of_ones;
		logic [OUT_BITS-1:0]   count_of_twos;
		logic [OUT_BITS-1:0]   count_of_fives;
		logic [OUT_BITS-1:0]   count_of_tens;
		logic [OUT_BITS-1:0]   count_of_twenties;
		logic [OUT_BITS-1:0]   count_of_fifties;
		logic [OUT_BITS-1:0]   count_of_hundreds;
	} out_item_t;

	typedef struct packed {
		logic                  en;
		logic [VALUE_BITS-1:0] note_value;
		logic [QTY_BITS-1:0]   qty;
	} dep_req_t;

	typedef struct packed {
		logic                  hit;
		logic                  ovf;
		logic [TOTAL_BITS-1:0] add;
	} dep_rsp_t;

	typedef struct packed {
		logic                vld;
		logic [REM_BITS-1:0] rem;
	} walk_t;

endpackage

// ----- rtl/core/bnid_cell.sv -----
module bnid_cell import bnid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IDX_BITS-1:0]   idx,
	input  dep_req_t              dep,
	output dep_rsp_t              dep_rsp,
	input  walk_t                 walk_in,
	output walk_t                 walk_out,
	input  logic                  commit,
	output logic [COUNT_BITS-1:0] count
);

	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] take_q;
	logic                  walk_vld_q;
	logic [REM_BITS-1:0]   walk_rem_q;

	logic [VALUE_BITS-1:0] face;
	logic [MAGIC_BITS-1:0] magic;
	logic                  hit;
	logic                  ovf;
	logic [SUM_BITS-1:0]   sum;
	logic [PROD_BITS-1:0]  prod;
	logic [REM_BITS-1:0]   quo;
	logic [WIDE_BITS-1:0]  quo_w;
	logic [WIDE_BITS-1:0]  cnt_w;
	logic [WIDE_BITS-1:0]  take_w;
	logic [REM_BITS-1:0]   rem_n;

	always_comb begin
		face  = FACE[idx];
		magic = MAGIC[idx];

		hit = dep.en && (dep.note_value == face);
		sum = SUM_BITS'(count_q) + SUM_BITS'(dep.qty);
		ovf = (sum[SUM_BITS-1:COUNT_BITS] != '0);

		dep_rsp.hit = hit;
		dep_rsp.ovf = hit && ovf;
		dep_rsp.add = (hit && !ovf) ? TOTAL_BITS'(dep.qty) * TOTAL_BITS'(face) : '0;

		// Notes of this face the remainder could use, capped by the notes on hand.
		prod   = PROD_BITS'(walk_in.rem) * PROD_BITS'(magic);
		quo    = prod[RECIP_SHIFT +: REM_BITS];
		quo_w  = WIDE_BITS'(quo);
		cnt_w  = WIDE_BITS'(count_q);
		take_w = (quo_w < cnt_w) ? quo_w : cnt_w;
		rem_n  = walk_in.rem - REM_BITS'(take_w) * REM_BITS'(face);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			walk_vld_q <= 1'b0;
		end else begin
			walk_vld_q <= walk_in.vld;
			if (hit && !ovf) begin
				count_q <= COUNT_BITS'(sum);
			end else if (commit) begin
				count_q <= count_q - take_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (walk_in.vld) begin
			walk_rem_q <= rem_n;
			take_q     <= COUNT_BITS'(take_w);
		end
	end

	assign walk_out.vld = walk_vld_q;
	assign walk_out.rem = walk_rem_q;
	assign count        = count_q;

endmodule

// ----- rtl/core/banknote_inventory_greedy_dispenser.sv -----
// Banknote inventory with a greedy dispenser for the faces 1, 2, 5, 10, 20, 50 and 100.
// A transaction is accepted on a rising edge with start high and busy low; cmd carries
// the operation and its fields. Each transaction gives one result on the result port,
// shown for exactly one cycle while done is high; the receiver cannot hold it off.
// Every operation but a withdrawal completes in the accepting edge: done is high in the
// next cycle and busy never rises, so a new transaction can be taken every cycle.
// A withdrawal passes its remainder down a row of seven cells, largest face first, one
// cell per cycle; each cell divides by its face with one reciprocal multiply. The edge
// after the smallest face commits or discards the takes and raises done; busy is high
// from acceptance until that edge, so no new transaction is taken during the walk.
// Results always show the counts and total after the transaction.
// Reset clears every count, the total and the result strobe; no clearing pass follows.

module banknote_inventory_greedy_dispenser import bnid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  cmd,
	output logic      done,
	output out_item_t result
);

	typedef enum logic {
		S_IDLE,
		S_WALK
	} state_t;

	state_t                state_q;
	logic                  done_q;
	status_t               status_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [REM_BITS-1:0]   amount_q;

	logic                  accept;
	logic                  is_dep;
	logic                  is_wd;
	dep_req_t              dep;
	dep_rsp_t              dep_rsp [NUM_DENOMS];
	walk_t                 walk_w [NUM_DENOMS+1];
	logic [NUM_DENOMS-1:0] walk_vld;
	logic [NUM_DENOMS-1:0][COUNT_BITS-1:0] cnt_w;
	logic                  dep_hit;
	logic                  dep_ovf;
	logic [TOTAL_BITS-1:0] dep_add;
	logic                  walk_end;
	logic                  commit;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		is_dep = 1'b0;
		is_wd  = 1'b0;
		unique case (cmd.op)
			OP_DEPOSIT:  is_dep = 1'b1;
			OP_WITHDRAW: is_wd  = 1'b1;
			default:     ;
		endcase
	end

	assign dep.en         = accept && is_dep;
	assign dep.note_value = cmd.note_value;
	assign dep.qty        = cmd.note_quantity;

	// The remainder enters at the hundreds cell and walks down towards the ones.
	assign walk_w[NUM_DENOMS].vld = accept && is_wd;
	assign walk_w[NUM_DENOMS].rem = cmd.amount;

	assign walk_end = walk_w[0].vld;
	assign commit   = walk_end && (walk_w[0].rem == '0);

	for (genvar i = 0; i < NUM_DENOMS; i++) begin : g_cell
		bnid_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (IDX_BITS'(i)),
			.dep      (dep),
			.dep_rsp  (dep_rsp[i]),
			.walk_in  (walk_w[i+1]),
			.walk_out (walk_w[i]),
			.commit   (commit),
			.count    (cnt_w[i])
		);
		assign walk_vld[i] = walk_w[i].vld;
	end

	always_comb begin
		dep_hit = 1'b0;
		dep_ovf = 1'b0;
		dep_add = '0;
		for (int i = 0; i < NUM_DENOMS; i++) begin
			dep_hit = dep_hit | dep_rsp[i].hit;
			dep_ovf = dep_ovf | dep_rsp[i].ovf;
			dep_add = dep_add | dep_rsp[i].add;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			total_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_wd) begin
							state_q <= S_WALK;
						end else begin
							done_q <= 1'b1;
							if (!is_dep) begin
								status_q <= ST_OK;
							end else if (!dep_hit) begin
								status_q <= ST_INVALID;
							end else if (dep_ovf) begin
								status_q <= ST_OVERFLOW;
							end else begin
								status_q <= ST_OK;
								total_q  <= total_q + dep_add;
							end
						end
					end
				end
				S_WALK: begin
					if (walk_end) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						if (commit) begin
							status_q <= ST_OK;
							total_q  <= total_q - TOTAL_BITS'(amount_q);
						end else begin
							status_q <= ST_UNAVAIL;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			amount_q <= cmd.amount;
		end
	end

	assign done                     = done_q;
	assign result.status            = status_q;
	assign result.total_value       = (total_q > TOTAL_BITS'(24'hFFFFFF)) ?
		24'hFFFFFF : total_q[REM_BITS-1:0];
	assign result.count_of_ones     = OUT_BITS'(cnt_w[0]);
	assign result.count_of_twos     = OUT_BITS'(cnt_w[1]);
	assign result.count_of_fives    = OUT_BITS'(cnt_w[2]);
	assign result.count_of_tens     = OUT_BITS'(cnt_w[3]);
	assign result.count_of_twenties = OUT_BITS'(cnt_w[4]);
	assign result.count_of_fifties  = OUT_BITS'(cnt_w[5]);
	assign result.count_of_hundreds = OUT_BITS'(cnt_w[6]);

	a_idle_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (walk_vld == '0))
		else $error("walk token present while idle");

	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(walk_vld))
		else $error("more than one withdrawal in the cell row");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> ($past(accept) || $past(walk_end)))
		else $error("result strobe without a finished transaction");

	a_unavail_keeps_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_UNAVAIL) |-> $stable(cnt_w))
		else $error("failed withdrawal changed the counts");

endmodule

// ----- bench/banknote_inventory_greedy_dispenser_tb.sv -----
`timescale 1ns / 100ps

module banknote_inventory_greedy_dispenser_tb;
	import bnid_pkg::*;

	localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;
	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
	localparam longint unsigned TOTAL_CAP = 64'hFF_FFFF;
	localparam int RANDOM_ITEMS = 700;
	localparam int CALM_ITEMS = 100;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		in_item_t  item;
		logic      typed;
		out_item_t want;
	} plan_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	in_item_t  cmd = '0;
	logic      cmd_typed = 1'b0;
	out_item_t cmd_want = '0;
	logic      busy;
	logic      done;
	out_item_t result;

	logic [COUNT_BITS-1:0] held_notes [NUM_DENOMS];
	out_item_t             pending_receipts [$];
	plan_row_t             steps [$];
	int                    mismatches = 0;
	string                 field_name [9] = '{"status", "total_value", "count_of_ones",
		"count_of_twos", "count_of_fives", "count_of_tens", "count_of_twenties",
		"count_of_fifties", "count_of_hundreds"};

	banknote_inventory_greedy_dispenser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #2 clk = ~clk;

	initial begin
		for (int i = 0; i < NUM_DENOMS; i++)
			held_notes[i] = '0;
	end

	function automatic longint unsigned held_total();
		longint unsigned total;
		total = 0;
		for (int i = 0; i < NUM_DENOMS; i++)
			total += held_notes[i] * FACE[i];
		return total;
	endfunction

	// Applies one transaction to the local inventory and returns the receipt it should give.
	function automatic out_item_t predict_receipt(input in_item_t item);
		out_item_t       r;
		longint unsigned rest, want, sum, total;
		longint unsigned taken [NUM_DENOMS];
		int              slot;
		r = '0;
		r.status = ST_OK;
		case (item.op)
			OP_DEPOSIT: begin
				slot = -1;
				for (int i = 0; i < NUM_DENOMS; i++)
					if (item.note_value == FACE[i])
						slot = i;
				if (slot < 0) begin
					r.status = ST_INVALID;
				end else begin
					sum = held_notes[slot];
					sum += item.note_quantity;
					if (sum > COUNT_MAX)
						r.status = ST_OVERFLOW;
					else
						held_notes[slot] = COUNT_BITS'(sum);
				end
			end
			OP_WITHDRAW: begin
				rest = item.amount;
				// Largest face first; nothing is taken unless the whole amount is covered.
				for (int i = NUM_DENOMS - 1; i >= 0; i--) begin
					want = rest / FACE[i];
					taken[i] = (want < held_notes[i]) ? want : held_notes[i];
					rest -= taken[i] * FACE[i];
				end
				if (rest != 0) begin
					r.status = ST_UNAVAIL;
				end else begin
					for (int i = 0; i < NUM_DENOMS; i++)
						held_notes[i] -= COUNT_BITS'(taken[i]);
				end
			end
			default: ;
		endcase
		total = held_total();
		if (total > TOTAL_CAP)
			total = TOTAL_CAP;
		r.total_value       = REM_BITS'(total);
		r.count_of_ones     = OUT_BITS'(held_notes[0]);
		r.count_of_twos     = OUT_BITS'(held_notes[1]);
		r.count_of_fives    = OUT_BITS'(held_notes[2]);
		r.count_of_tens     = OUT_BITS'(held_notes[3]);
		r.count_of_twenties = OUT_BITS'(held_notes[4]);
		r.count_of_fifties  = OUT_BITS'(held_notes[5]);
		r.count_of_hundreds = OUT_BITS'(held_notes[6]);
		return r;
	endfunction

	function automatic void split_receipt(input out_item_t r, output longint unsigned f [9]);
		f[0] = r.status;
		f[1] = r.total_value;
		f[2] = r.count_of_ones;
		f[3] = r.count_of_twos;
		f[4] = r.count_of_fives;
		f[5] = r.count_of_tens;
		f[6] = r.count_of_twenties;
		f[7] = r.count_of_fifties;
		f[8] = r.count_of_hundreds;
	endfunction

	function automatic out_item_t tally(input status_t st, input int unsigned total,
		input int unsigned n1, n2, n5, n10, n20, n50, n100);
		out_item_t r;
		r.status            = st;
		r.total_value       = REM_BITS'(total);
		r.count_of_ones     = OUT_BITS'(n1);
		r.count_of_twos     = OUT_BITS'(n2);
		r.count_of_fives    = OUT_BITS'(n5);
		r.count_of_tens     = OUT_BITS'(n10);
		r.count_of_twenties = OUT_BITS'(n20);
		r.count_of_fifties  = OUT_BITS'(n50);
		r.count_of_hundreds = OUT_BITS'(n100);
		return r;
	endfunction

	function automatic plan_row_t step_row(input logic [OP_BITS-1:0] op,
		input int unsigned value, qty, amt, input bit typed = 1'b0, input out_item_t want = '0);
		plan_row_t s;
		s.item.op            = op;
		s.item.note_value    = VALUE_BITS'(value);
		s.item.note_quantity = QTY_BITS'(qty);
		s.item.amount        = REM_BITS'(amt);
		s.typed              = typed;
		s.want               = want;
		return s;
	endfunction

	// Mostly sensible deposits and withdrawals sized from the current inventory, some queries
	// and spare opcodes, with junk in every field the operation does not read.
	function automatic in_item_t random_cmd();
		in_item_t        c;
		logic [63:0]     noise;
		int unsigned     slot;
		longint unsigned total;
		int unsigned     pick;
		noise = {$urandom, $urandom};
		c = noise[$bits(in_item_t)-1:0];
		total = held_total();
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			c.op = OP_DEPOSIT;
			slot = $urandom_range(0, NUM_DENOMS - 1);
			if ($urandom_range(0, 9) != 0)
				c.note_value = FACE[slot];
			case ($urandom_range(0, 9))
				0, 1: ;
				2: c.note_quantity = QTY_BITS'(COUNT_MAX - held_notes[slot] + $urandom_range(0, 1));
				default: c.note_quantity = QTY_BITS'($urandom_range(0, 40));
			endcase
		end else if (pick < 80) begin
			c.op = OP_WITHDRAW;
			case ($urandom_range(0, 6))
				0: c.amount = REM_BITS'(total);
				1: ;
				2, 3: c.amount = REM_BITS'($urandom_range(0, 300));
				default: c.amount = REM_BITS'($urandom_range(0, 32'(total)));
			endcase
		end else if (pick < 92) begin
			c.op = OP_QUERY;
		end else begin
			c.op = OP_SPARE;
		end
		return c;
	endfunction

	task automatic check_receipt(input out_item_t got);
		out_item_t       want;
		longint unsigned w [9];
		longint unsigned g [9];
		if (pending_receipts.size() == 0) begin
			mismatches++;
			$display("%0t ns: receipt with none expected, status %0d total %0d",
				$time, got.status, got.total_value);
		end else begin
			want = pending_receipts.pop_front();
			split_receipt(want, w);
			split_receipt(got, g);
			for (int i = 0; i < 9; i++) begin
				if (w[i] != g[i]) begin
					mismatches++;
					$display("%0t ns: %s expected %0d, got %0d",
						$time, field_name[i], w[i], g[i]);
				end
			end
		end
	endtask

	// Results are checked before the transaction accepted at the same edge is predicted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				check_receipt(result);
			if (start && !busy) begin
				if (cmd_typed) begin
					void'(predict_receipt(cmd));
					pending_receipts.push_back(cmd_want);
				end else begin
					pending_receipts.push_back(predict_receipt(cmd));
				end
			end
		end
	end

	task automatic send_transaction(input in_item_t item, input bit typed,
		input out_item_t want, input bit may_idle);
		if (may_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		start     <= 1'b1;
		cmd       <= item;
		cmd_typed <= typed;
		cmd_want  <= want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	initial begin
		steps = '{
			step_row(OP_QUERY, 0, 0, 0, 1'b1, tally(ST_OK, 0, 0, 0, 0, 0, 0, 0, 0)),
			step_row(OP_WITHDRAW, 0, 0, 0, 1'b1, tally(ST_OK, 0, 0, 0, 0, 0, 0, 0, 0)),
			step_row(OP_WITHDRAW, 0, 0, 24'hFF_FFFF, 1'b1,
				tally(ST_UNAVAIL, 0, 0, 0, 0, 0, 0, 0, 0)),
			step_row(OP_DEPOSIT, 3, 5, 0, 1'b1, tally(ST_INVALID, 0, 0, 0, 0, 0, 0, 0, 0)),
			step_row(OP_DEPOSIT, 0, 16'hFFFF, 24'hFF_FFFF, 1'b1,
				tally(ST_INVALID, 0, 0, 0, 0, 0, 0, 0, 0)),
			step_row(OP_DEPOSIT, 255, 1, 0, 1'b1, tally(ST_INVALID, 0, 0, 0, 0, 0, 0, 0, 0)),
			step_row(OP_DEPOSIT, 1, 0, 77, 1'b1, tally(ST_OK, 0, 0, 0, 0, 0, 0, 0, 0)),
			step_row(OP_DEPOSIT, 100, 16'hFFFF, 0, 1'b1,
				tally(ST_OK, 6553500, 0, 0, 0, 0, 0, 0, 16'hFFFF)),
			step_row(OP_DEPOSIT, 100, 1, 0, 1'b1,
				tally(ST_OVERFLOW, 6553500, 0, 0, 0, 0, 0, 0, 16'hFFFF)),
			step_row(OP_DEPOSIT, 1, 16'hFFFF, 24'hAA_5555),
			step_row(OP_DEPOSIT, 2, 16'hFFFF, 0),
			step_row(OP_DEPOSIT, 5, 16'hFFFF, 0),
			step_row(OP_DEPOSIT, 10, 16'hFFFF, 0),
			step_row(OP_DEPOSIT, 20, 16'hFFFF, 0),
			step_row(OP_DEPOSIT, 50, 16'hFFFF, 0),
			step_row(OP_SPARE, 255, 16'hFFFF, 24'hFF_FFFF),
			step_row(OP_QUERY, 20, 3, 40, 1'b1, tally(ST_OK, 12320580, 16'hFFFF, 16'hFFFF,
				16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF)),
			step_row(OP_WITHDRAW, 0, 0, 24'hFF_FFFF, 1'b1, tally(ST_UNAVAIL, 12320580,
				16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF)),
			step_row(OP_WITHDRAW, 255, 16'hFFFF, 12320580, 1'b1,
				tally(ST_OK, 0, 0, 0, 0, 0, 0, 0, 0)),
			step_row(OP_DEPOSIT, 5, 3, 0),
			step_row(OP_DEPOSIT, 2, 4, 0),
			// Greedy takes the five first and is then left one short.
			step_row(OP_WITHDRAW, 0, 0, 6),
			step_row(OP_WITHDRAW, 0, 0, 8),
			step_row(OP_WITHDRAW, 0, 0, 9),
			step_row(OP_WITHDRAW, 100, 16'hFFFF, 0)
		};
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (steps[i])
			send_transaction(steps[i].item, steps[i].typed, steps[i].want, 1'b1);
		for (int n = 0; n < RANDOM_ITEMS; n++)
			send_transaction(random_cmd(), 1'b0, '0, n < RANDOM_ITEMS - CALM_ITEMS);
		start <= 1'b0;
		@(posedge clk);
		while (pending_receipts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#1000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
